// File: rtl/core/secl_pkg.sv
package secl_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int VERTICES       = 3;
   localparam int CSR_IDX_BITS   = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_A_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_A_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_B_X = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_B_Y = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_C_X = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_C_Y = 3'd5;

endpackage

// File: rtl/core/segment_exterior_clip_triangle.sv
// Clips one segment per transfer against the triangle held in the vertex registers and
// returns the parts outside it: none, one or two pieces, the final one flagged by
// rsp_last_piece. A new segment is accepted every cycle while the result port keeps up;
// a segment with two pieces holds the result port until both have been taken. The edge
// divider resolves one quotient bit per pipeline stage. Vertex registers must only be
// written while idle.
module segment_exterior_clip_triangle
   import secl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_piece_start_x,
   output logic signed [COORD_BITS-1:0] rsp_piece_start_y,
   output logic signed [COORD_BITS-1:0] rsp_piece_end_x,
   output logic signed [COORD_BITS-1:0] rsp_piece_end_y,
   output logic                         rsp_last_piece,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]        csr_write_data
);

   localparam int CW    = COORD_BITS;
   localparam int DW    = CW + 1;
   localparam int PW    = 2 * DW;
   localparam int SW    = PW + 1;
   localparam int OPW   = SW - 1;
   localparam int TW    = FRAC_BITS + 1;
   localparam int QBITS = FRAC_BITS + 2;
   localparam int MW    = DW + TW + 1;
   localparam int NV    = VERTICES;

   localparam logic [TW-1:0]        T_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [MW:0]          HALF   = (MW+1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [MW+1:0] SAT_HI = {{(MW+3-CW){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [MW+1:0] SAT_LO = {{(MW+3-CW){1'b1}}, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic              rej;
      logic [NV-1:0]     ent;
      logic [NV-1:0]     lev;
   } trk_type;

   typedef enum logic [2:0] {
      MODE_WHOLE,
      MODE_NONE,
      MODE_TAIL,
      MODE_HEAD,
      MODE_BOTH
   } mode_type;

   function automatic logic signed [DW-1:0] ext1(input logic signed [CW-1:0] v);
      return {v[CW-1], v};
   endfunction

   function automatic logic signed [CW-1:0] clip_f(input logic signed [CW-1:0] s,
                                                   input logic signed [MW-1:0] p);
      logic [MW-1:0]        mag;
      logic [MW:0]          rnd;
      logic signed [MW+1:0] sum;
      mag = p[MW-1] ? MW'(-p) : MW'(p);
      rnd = ({1'b0, mag} + HALF) >> FRAC_BITS;
      if (p[MW-1]) begin
         sum = $signed({{(MW+2-CW){s[CW-1]}}, s}) - $signed({1'b0, rnd});
      end else begin
         sum = $signed({{(MW+2-CW){s[CW-1]}}, s}) + $signed({1'b0, rnd});
      end
      if (sum > SAT_HI) begin
         sum = SAT_HI;
      end else if (sum < SAT_LO) begin
         sum = SAT_LO;
      end
      return sum[CW-1:0];
   endfunction

   logic signed [CW-1:0] vx_ff [NV];
   logic signed [CW-1:0] vy_ff [NV];

   logic adv;
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [QBITS-1:0] vd_ff;

   side_type side0_ff, side1_ff, side2_ff, side3_ff;
   logic signed [DW-1:0] nx1_ff [NV];
   logic signed [DW-1:0] ny1_ff [NV];
   logic signed [DW-1:0] wx1_ff [NV];
   logic signed [DW-1:0] wy1_ff [NV];
   logic signed [PW-1:0] pd1_ff [NV];
   logic signed [PW-1:0] pd2_ff [NV];
   logic signed [PW-1:0] pn1_ff [NV];
   logic signed [PW-1:0] pn2_ff [NV];
   logic signed [SW-1:0] den3_ff [NV];
   logic signed [SW-1:0] num3_ff [NV];

   trk_type              trk4_in, trk4_ff;
   logic [OPW-1:0]       opn4_in [NV];
   logic [OPW-1:0]       opd4_in [NV];
   logic [OPW-1:0]       opn4_ff [NV];
   logic [OPW-1:0]       opd4_ff [NV];
   logic signed [SW-1:0] nneg_w [NV];
   logic signed [SW-1:0] dneg_w [NV];

   trk_type              trkd_ff [QBITS];
   logic [TW-1:0]        t_w [NV];

   logic [TW-1:0]        te5_in, tl5_in, te5_ff, tl5_ff;
   side_type             side5_ff, side6_ff;
   logic                 rej5_ff;

   mode_type             mode6_in, mode6_ff;
   logic signed [MW-1:0] mxe6_ff, mye6_ff, mxl6_ff, myl6_ff;

   logic                 ob_valid_ff, ob_two_ff, ob_sel_ff;
   logic                 ob_valid_in, ob_two_in;
   logic signed [CW-1:0] p0_in [4];
   logic signed [CW-1:0] p1_in [4];
   logic signed [CW-1:0] p0_ff [4];
   logic signed [CW-1:0] p1_ff [4];
   logic signed [CW-1:0] cex_w, cey_w, clx_w, cly_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NV; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_A_X: vx_ff[0] <= csr_write_data;
            REG_A_Y: vy_ff[0] <= csr_write_data;
            REG_B_X: vx_ff[1] <= csr_write_data;
            REG_B_Y: vy_ff[1] <= csr_write_data;
            REG_C_X: vx_ff[2] <= csr_write_data;
            REG_C_Y: vy_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign rsp_last_piece = !ob_two_ff || ob_sel_ff;
   assign adv            = !ob_valid_ff || (rsp_ready && rsp_last_piece);
   assign req_ready      = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vd_ff <= '0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vd_ff <= {vd_ff[QBITS-2:0], v4_ff};
         v5_ff <= vd_ff[QBITS-1];
         v6_ff <= v5_ff;
      end
   end

   always_comb begin
      trk4_in.side = side3_ff;
      trk4_in.rej  = 1'b0;
      trk4_in.ent  = '0;
      trk4_in.lev  = '0;
      for (int i = 0; i < NV; i++) begin
         nneg_w[i]  = -num3_ff[i];
         dneg_w[i]  = -den3_ff[i];
         opn4_in[i] = '0;
         opd4_in[i] = '0;
         if (den3_ff[i] > 0) begin
            opn4_in[i] = num3_ff[i][OPW-1:0];
            opd4_in[i] = den3_ff[i][OPW-1:0];
            if (num3_ff[i] > den3_ff[i]) begin
               trk4_in.rej = 1'b1;
            end else if (num3_ff[i] > 0) begin
               trk4_in.ent[i] = 1'b1;
            end
         end else if (den3_ff[i] < 0) begin
            opn4_in[i] = nneg_w[i][OPW-1:0];
            opd4_in[i] = dneg_w[i][OPW-1:0];
            if (nneg_w[i] < 0) begin
               trk4_in.rej = 1'b1;
            end else if (nneg_w[i] < dneg_w[i]) begin
               trk4_in.lev[i] = 1'b1;
            end
         end else if (num3_ff[i] > 0) begin
            // Parallel edge with the start point on its outer side.
            trk4_in.rej = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side0_ff.sx <= req_start_x;
         side0_ff.sy <= req_start_y;
         side0_ff.ex <= req_end_x;
         side0_ff.ey <= req_end_y;
         side0_ff.dx <= ext1(req_end_x) - ext1(req_start_x);
         side0_ff.dy <= ext1(req_end_y) - ext1(req_start_y);
         side1_ff    <= side0_ff;
         side2_ff    <= side1_ff;
         side3_ff    <= side2_ff;
         for (int i = 0; i < NV; i++) begin
            nx1_ff[i]  <= ext1(vy_ff[i]) - ext1(vy_ff[(i + 1) % NV]);
            ny1_ff[i]  <= ext1(vx_ff[(i + 1) % NV]) - ext1(vx_ff[i]);
            wx1_ff[i]  <= ext1(vx_ff[i]) - ext1(side0_ff.sx);
            wy1_ff[i]  <= ext1(vy_ff[i]) - ext1(side0_ff.sy);
            pd1_ff[i]  <= nx1_ff[i] * side1_ff.dx;
            pd2_ff[i]  <= ny1_ff[i] * side1_ff.dy;
            pn1_ff[i]  <= nx1_ff[i] * wx1_ff[i];
            pn2_ff[i]  <= ny1_ff[i] * wy1_ff[i];
            den3_ff[i] <= SW'(pd1_ff[i]) + SW'(pd2_ff[i]);
            num3_ff[i] <= SW'(pn1_ff[i]) + SW'(pn2_ff[i]);
            opn4_ff[i] <= opn4_in[i];
            opd4_ff[i] <= opd4_in[i];
         end
         trk4_ff    <= trk4_in;
         trkd_ff[0] <= trk4_ff;
         for (int k = 1; k < QBITS; k++) begin
            trkd_ff[k] <= trkd_ff[k-1];
         end
      end
   end

   for (genvar g = 0; g < NV; g++) begin : g_div
      secl_div #(
         .OPW   (OPW),
         .QBITS (QBITS)
      ) u_div (
         .clock  (clock),
         .enable (adv),
         .num_in (opn4_ff[g]),
         .den_in (opd4_ff[g]),
         .t_out  (t_w[g])
      );
   end

   always_comb begin
      te5_in = '0;
      tl5_in = T_ONE;
      for (int i = 0; i < NV; i++) begin
         if (trkd_ff[QBITS-1].ent[i] && (t_w[i] > te5_in)) begin
            te5_in = t_w[i];
         end
         if (trkd_ff[QBITS-1].lev[i] && (t_w[i] < tl5_in)) begin
            tl5_in = t_w[i];
         end
      end
   end

   always_comb begin
      if (rej5_ff || (te5_ff > tl5_ff)) begin
         mode6_in = MODE_WHOLE;
      end else if ((te5_ff == '0) && (tl5_ff == T_ONE)) begin
         mode6_in = MODE_NONE;
      end else if (te5_ff == '0) begin
         mode6_in = MODE_TAIL;
      end else if (tl5_ff == T_ONE) begin
         mode6_in = MODE_HEAD;
      end else begin
         mode6_in = MODE_BOTH;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         te5_ff   <= te5_in;
         tl5_ff   <= tl5_in;
         rej5_ff  <= trkd_ff[QBITS-1].rej;
         side5_ff <= trkd_ff[QBITS-1].side;
         mode6_ff <= mode6_in;
         side6_ff <= side5_ff;
         mxe6_ff  <= side5_ff.dx * $signed({1'b0, te5_ff});
         mye6_ff  <= side5_ff.dy * $signed({1'b0, te5_ff});
         mxl6_ff  <= side5_ff.dx * $signed({1'b0, tl5_ff});
         myl6_ff  <= side5_ff.dy * $signed({1'b0, tl5_ff});
      end
   end

   assign cex_w = clip_f(side6_ff.sx, mxe6_ff);
   assign cey_w = clip_f(side6_ff.sy, mye6_ff);
   assign clx_w = clip_f(side6_ff.sx, mxl6_ff);
   assign cly_w = clip_f(side6_ff.sy, myl6_ff);

   always_comb begin
      ob_valid_in = v6_ff && (mode6_ff != MODE_NONE);
      ob_two_in   = 1'b0;
      p0_in[0]    = side6_ff.sx;
      p0_in[1]    = side6_ff.sy;
      p0_in[2]    = side6_ff.ex;
      p0_in[3]    = side6_ff.ey;
      p1_in[0]    = clx_w;
      p1_in[1]    = cly_w;
      p1_in[2]    = side6_ff.ex;
      p1_in[3]    = side6_ff.ey;
      unique case (mode6_ff)
         MODE_TAIL: begin
            p0_in[0] = clx_w;
            p0_in[1] = cly_w;
         end
         MODE_HEAD: begin
            p0_in[2] = cex_w;
            p0_in[3] = cey_w;
         end
         MODE_BOTH: begin
            p0_in[2]  = cex_w;
            p0_in[3]  = cey_w;
            ob_two_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_valid_ff <= 1'b0;
         ob_two_ff   <= 1'b0;
         ob_sel_ff   <= 1'b0;
      end else if (adv) begin
         ob_valid_ff <= ob_valid_in;
         ob_two_ff   <= ob_two_in;
         ob_sel_ff   <= 1'b0;
      end else if (rsp_ready) begin
         ob_sel_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
      end
   end

   assign rsp_valid         = ob_valid_ff;
   assign rsp_piece_start_x = ob_sel_ff ? p1_ff[0] : p0_ff[0];
   assign rsp_piece_start_y = ob_sel_ff ? p1_ff[1] : p0_ff[1];
   assign rsp_piece_end_x   = ob_sel_ff ? p1_ff[2] : p0_ff[2];
   assign rsp_piece_end_y   = ob_sel_ff ? p1_ff[3] : p0_ff[3];

   a_sel_only_on_pair: assert property (@(posedge clock) disable iff (reset)
      ob_sel_ff |-> (ob_two_ff && ob_valid_ff))
      else $error("second piece selected without a pair");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_piece) |=> (rsp_valid && rsp_last_piece))
      else $error("first piece of a pair not followed by the last piece");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(v6_ff) && $stable(vd_ff)))
      else $error("pipeline moved during a stall");

endmodule

// File: rtl/core/secl_div.sv
module secl_div
   import secl_pkg::*;
#(
   parameter int OPW   = 2 * (COORD_BITS_DEF + 1),
   parameter int QBITS = FRAC_BITS_DEF + 2
)
(
   input  logic             clock,
   input  logic             enable,
   input  logic [OPW-1:0]   num_in,
   input  logic [OPW-1:0]   den_in,
   output logic [QBITS-2:0] t_out
);

   // One quotient bit per stage; the first stage subtracts the divisor once if the dividend is at least as large.
   logic [OPW-1:0]   r_ff [QBITS];
   logic [OPW-1:0]   d_ff [QBITS];
   logic [QBITS-1:0] q_ff [QBITS];
   logic [OPW-1:0]   r_in [QBITS];
   logic [OPW-1:0]   d_in [QBITS];
   logic [QBITS-1:0] q_in [QBITS];
   logic [OPW:0]     sh_w [QBITS];
   logic [QBITS:0]   qp_w;

   always_comb begin
      sh_w[0] = '0;
      d_in[0] = den_in;
      if (num_in >= den_in) begin
         q_in[0] = QBITS'(1);
         r_in[0] = num_in - den_in;
      end else begin
         q_in[0] = '0;
         r_in[0] = num_in;
      end
      for (int k = 1; k < QBITS; k++) begin
         sh_w[k] = {r_ff[k-1], 1'b0};
         d_in[k] = d_ff[k-1];
         if (sh_w[k] >= {1'b0, d_ff[k-1]}) begin
            r_in[k] = OPW'(sh_w[k] - {1'b0, d_ff[k-1]});
            q_in[k] = {q_ff[k-1][QBITS-2:0], 1'b1};
         end else begin
            r_in[k] = sh_w[k][OPW-1:0];
            q_in[k] = {q_ff[k-1][QBITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < QBITS; k++) begin
            r_ff[k] <= r_in[k];
            d_ff[k] <= d_in[k];
            q_ff[k] <= q_in[k];
         end
      end
   end

   assign qp_w  = {1'b0, q_ff[QBITS-1]} + (QBITS+1)'(1);
   assign t_out = qp_w[QBITS-1:1];

endmodule
